### rtl/dxt_pkg.sv
// Shared types and arithmetic helpers for the DXT block decoder.
`timescale 1ns / 1ps

package dxt_pkg;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	// Expanded endpoints of one block, handed to the palette builder.
	typedef struct packed {
		rgb_t       e0;
		rgb_t       e1;
		logic       four;
		logic [7:0] a0;
		logic [7:0] a1;
	} endpoints_t;

	// Colour palette and the full alpha table of one block.
	typedef struct packed {
		rgb_t [3:0]      col;
		logic [7:0][7:0] atab;
	} palette_t;

	localparam logic [3:0] LastPixel = 4'd15;
	localparam logic [7:0] AlphaOpaque = 8'd255;
	localparam logic [7:0] AlphaClear = 8'd0;
	localparam logic [1:0] TransparentIndex = 2'd3;

	// 5-bit to 8-bit expansion: t = c*255 + 16, result ((t >> 5) + t) >> 5.
	function automatic logic [7:0] expand5(input logic [4:0] c);
		logic [12:0] t;
		logic [12:0] s;
		t = {c, 8'd0} - 13'(c) + 13'd16;
		s = t + 13'(t[12:5]);
		return s[12:5];
	endfunction

	// 6-bit to 8-bit expansion: t = c*255 + 32, result ((t >> 6) + t) >> 6.
	function automatic logic [7:0] expand6(input logic [5:0] c);
		logic [13:0] t;
		logic [13:0] s;
		t = {c, 8'd0} - 14'(c) + 14'd32;
		s = t + 14'(t[13:6]);
		return s[13:6];
	endfunction

	// Exact floor(x / 3) for x up to 765.
	function automatic logic [7:0] div3(input logic [9:0] x);
		logic [19:0] p;
		p = 20'(x) * 20'd683;
		return p[18:11];
	endfunction

	// Exact floor(x / 7) for x up to 1785.
	function automatic logic [7:0] div7(input logic [10:0] x);
		logic [22:0] p;
		p = 23'(x) * 23'd2341;
		return p[21:14];
	endfunction

	// Exact floor(x / 5) for x up to 1275.
	function automatic logic [7:0] div5(input logic [10:0] x);
		logic [22:0] p;
		p = 23'(x) * 23'd3277;
		return p[21:14];
	endfunction

endpackage

### rtl/dxt_block_if.sv
// Valid/ready channel carrying one compressed block.
`timescale 1ns / 1ps

interface dxt_block_if;
	logic        valid;
	logic        ready;
	logic [63:0] first_word;
	logic [63:0] second_word;

	modport source (output valid, output first_word, output second_word, input ready);
	modport sink (input valid, input first_word, input second_word, output ready);
endinterface

### rtl/dxt_pixel_if.sv
// Valid/ready channel carrying one decoded RGBA8 pixel.
`timescale 1ns / 1ps

interface dxt_pixel_if;
	logic       valid;
	logic       ready;
	logic [3:0] pixel_index;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;
	logic       last_pixel;

	modport source (output valid, output pixel_index, output red, output green,
		output blue, output alpha, output last_pixel, input ready);
	modport sink (input valid, input pixel_index, input red, input green,
		input blue, input alpha, input last_pixel, output ready);
endinterface

### rtl/dxt_palette.sv
// Builds the four-entry colour palette and eight-entry alpha table of a block.
`timescale 1ns / 1ps

module dxt_palette (
	input  dxt_pkg::endpoints_t ep,
	output dxt_pkg::palette_t   pal
);

	function automatic logic [7:0] alpha_entry(input logic [7:0] a0, input logic [7:0] a1,
		input logic [2:0] code);
		logic [2:0]  k0;
		logic [2:0]  k1;
		logic [10:0] sum;
		logic [7:0]  res;
		k0 = 3'(4'd8 - {1'b0, code});
		k1 = code - 3'd1;
		sum = 11'(k0) * 11'(a0) + 11'(k1) * 11'(a1);
		if (code == 3'd0) begin
			res = a0;
		end else if (code == 3'd1) begin
			res = a1;
		end else if (a0 > a1) begin
			res = dxt_pkg::div7(sum);
		end else if (code == 3'd6) begin
			res = dxt_pkg::AlphaClear;
		end else if (code == 3'd7) begin
			res = dxt_pkg::AlphaOpaque;
		end else begin
			// Six-value mode uses weights (6 - code) and (code - 1).
			k0 = 3'd6 - code;
			sum = 11'(k0) * 11'(a0) + 11'(k1) * 11'(a1);
			res = dxt_pkg::div5(sum);
		end
		return res;
	endfunction

	function automatic logic [7:0] third(input logic [7:0] near, input logic [7:0] far);
		return dxt_pkg::div3({1'b0, near, 1'b0} + 10'(far));
	endfunction

	function automatic logic [7:0] mean(input logic [7:0] x, input logic [7:0] y);
		logic [8:0] s;
		s = 9'(x) + 9'(y);
		return s[8:1];
	endfunction

	always_comb begin
		pal.col[0] = ep.e0;
		pal.col[1] = ep.e1;
		if (ep.four) begin
			pal.col[2].r = third(ep.e0.r, ep.e1.r);
			pal.col[2].g = third(ep.e0.g, ep.e1.g);
			pal.col[2].b = third(ep.e0.b, ep.e1.b);
			pal.col[3].r = third(ep.e1.r, ep.e0.r);
			pal.col[3].g = third(ep.e1.g, ep.e0.g);
			pal.col[3].b = third(ep.e1.b, ep.e0.b);
		end else begin
			pal.col[2].r = mean(ep.e0.r, ep.e1.r);
			pal.col[2].g = mean(ep.e0.g, ep.e1.g);
			pal.col[2].b = mean(ep.e0.b, ep.e1.b);
			pal.col[3] = '0;
		end
		for (int i = 0; i < 8; i++) begin
			pal.atab[i] = alpha_entry(ep.a0, ep.a1, 3'(i));
		end
	end

endmodule

### rtl/dxt_texture_block_decoder.sv
// Top level of the DXT1/DXT5 block decoder: block in, sixteen pixels out.
//
//   channel   direction  contents
//   blocks    in         first_word, second_word (one 4x4 block per transaction)
//   pixels    out        pixel_index, red, green, blue, alpha, last_pixel
//   cfg       in         cfg_we, cfg_wdata (block_format: 0 DXT1, 1 DXT5)
//
// Each block produces sixteen pixel transactions, one per cycle while the
// pixel receiver is ready; the pixel port sets the sustained rate. The first
// pixel passes the input, endpoint, palette and output registers. The next
// block is accepted while the current one is still emitting. Reset clears
// all valid flags, the pixel counter and block_format. Output stalls back
// up through the stages.
`timescale 1ns / 1ps

module dxt_texture_block_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	dxt_block_if.sink         blocks,
	dxt_pixel_if.source       pixels
);

	logic block_format_q;

	// Stage 1: raw block.
	logic        valid_s1;
	logic        fmt_s1;
	logic [63:0] first_s1;
	logic [63:0] second_s1;

	// Stage 2: expanded endpoints and index bits.
	logic                 valid_s2;
	logic                 fmt_s2;
	dxt_pkg::endpoints_t  ep_s2;
	logic [31:0]          cidx_s2;
	logic [47:0]          aidx_s2;

	// Stage 3: palette, alpha table and index bits; pixels are read out here.
	logic                 valid_s3;
	logic                 fmt_s3;
	logic                 four_s3;
	dxt_pkg::palette_t    pal_s3;
	logic [31:0]          cidx_s3;
	logic [47:0]          aidx_s3;
	logic [3:0]           cnt_q;

	// Output register.
	logic       out_valid_q;
	logic [3:0] pixel_index_q;
	logic [7:0] red_q;
	logic [7:0] green_q;
	logic [7:0] blue_q;
	logic [7:0] alpha_q;
	logic       last_pixel_q;

	logic emit;
	logic s3_done;
	logic load_s3;
	logic load_s2;

	logic [63:0]         colour_word;
	logic [15:0]         c0;
	logic [15:0]         c1;
	dxt_pkg::endpoints_t ep_next;
	dxt_pkg::palette_t   pal_next;

	logic [1:0] ci;
	logic [2:0] code;
	logic [5:0] abit;
	logic [7:0] pix_alpha;

	assign emit    = valid_s3 && (!out_valid_q || pixels.ready);
	assign s3_done = emit && (cnt_q == dxt_pkg::LastPixel);
	assign load_s3 = valid_s2 && (!valid_s3 || s3_done);
	assign load_s2 = valid_s1 && (!valid_s2 || load_s3);
	assign blocks.ready = !valid_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_format_q <= 1'b0;
		end else if (cfg_we) begin
			block_format_q <= cfg_wdata;
		end
	end

	// Endpoint expansion between stage 1 and stage 2.
	always_comb begin
		colour_word = fmt_s1 ? second_s1 : first_s1;
		c0 = colour_word[15:0];
		c1 = colour_word[31:16];
		ep_next.e0.r = dxt_pkg::expand5(c0[15:11]);
		ep_next.e0.g = dxt_pkg::expand6(c0[10:5]);
		ep_next.e0.b = dxt_pkg::expand5(c0[4:0]);
		ep_next.e1.r = dxt_pkg::expand5(c1[15:11]);
		ep_next.e1.g = dxt_pkg::expand6(c1[10:5]);
		ep_next.e1.b = dxt_pkg::expand5(c1[4:0]);
		ep_next.four = fmt_s1 || (c0 > c1);
		ep_next.a0 = first_s1[7:0];
		ep_next.a1 = first_s1[15:8];
	end

	dxt_palette u_palette (
		.ep  (ep_s2),
		.pal (pal_next)
	);

	// Per-pixel selection out of stage 3.
	always_comb begin
		ci = cidx_s3[{cnt_q, 1'b0} +: 2];
		abit = 6'(cnt_q) * 6'd3;
		code = aidx_s3[abit +: 3];
		if (fmt_s3) begin
			pix_alpha = pal_s3.atab[code];
		end else if (!four_s3 && ci == dxt_pkg::TransparentIndex) begin
			pix_alpha = dxt_pkg::AlphaClear;
		end else begin
			pix_alpha = dxt_pkg::AlphaOpaque;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (blocks.ready) begin
				valid_s1 <= blocks.valid;
			end
			if (!valid_s2 || load_s3) begin
				valid_s2 <= valid_s1;
			end
			if (!valid_s3 || s3_done) begin
				valid_s3 <= valid_s2;
			end
			if (emit) begin
				cnt_q <= cnt_q + 4'd1;
			end
			if (!out_valid_q || pixels.ready) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (blocks.ready) begin
			fmt_s1 <= block_format_q;
			first_s1 <= blocks.first_word;
			second_s1 <= blocks.second_word;
		end
		if (!valid_s2 || load_s3) begin
			fmt_s2 <= fmt_s1;
			ep_s2 <= ep_next;
			cidx_s2 <= colour_word[63:32];
			aidx_s2 <= first_s1[63:16];
		end
		if (!valid_s3 || s3_done) begin
			fmt_s3 <= fmt_s2;
			four_s3 <= ep_s2.four;
			pal_s3 <= pal_next;
			cidx_s3 <= cidx_s2;
			aidx_s3 <= aidx_s2;
		end
		if (emit) begin
			pixel_index_q <= cnt_q;
			red_q <= pal_s3.col[ci].r;
			green_q <= pal_s3.col[ci].g;
			blue_q <= pal_s3.col[ci].b;
			alpha_q <= pix_alpha;
			last_pixel_q <= (cnt_q == dxt_pkg::LastPixel);
		end
	end

	assign pixels.valid = out_valid_q;
	assign pixels.pixel_index = pixel_index_q;
	assign pixels.red = red_q;
	assign pixels.green = green_q;
	assign pixels.blue = blue_q;
	assign pixels.alpha = alpha_q;
	assign pixels.last_pixel = last_pixel_q;

`ifndef SYNTH
	// A block part-way through its pixels must still be held in stage 3.
	a_cnt_owned: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != 4'd0) |-> valid_s3)
		else $error("pixel counter active without a block in stage 3");

	// The marker and the position of a pending pixel must agree.
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (last_pixel_q == (pixel_index_q == dxt_pkg::LastPixel)))
		else $error("last_pixel does not match pixel_index");

	// A block transaction only lands in an empty or draining stage 1.
	a_s1_free: assert property (@(posedge clk) disable iff (!arst_n)
		(blocks.valid && blocks.ready) |-> (!valid_s1 || load_s2))
		else $error("block accepted over a held block");

	// Stage 3 empties after its last pixel when nothing follows.
	a_s3_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(s3_done && !load_s3) |=> !valid_s3)
		else $error("stage 3 kept a finished block");
`endif

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the DXT1/DXT5 texture block decoder.
`timescale 1ns / 1ps

module tb_top;

	localparam logic FMT_DXT1 = 1'b0;
	localparam logic FMT_DXT5 = 1'b1;

	localparam logic [2:0] ACODE_A0 = 3'd0;
	localparam logic [2:0] ACODE_A1 = 3'd1;
	localparam logic [2:0] ACODE_CLEAR = 3'd6;
	localparam logic [2:0] ACODE_OPAQUE = 3'd7;

	localparam int CYCLE_LIMIT = 600000;
	localparam int TAIL_CYCLES = 24;
	localparam int PHASE_COUNT = 6;
	localparam int PHASE_ITEMS = 60;

	typedef struct packed {
		logic [3:0] idx;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last;
	} pixel_t;

	typedef struct packed {
		logic        fmt;
		logic [63:0] fw;
		logic [63:0] sw;
		logic        typed;
		logic [31:0] rgba;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	dxt_block_if blocks ();
	dxt_pixel_if pixels ();

	dxt_texture_block_decoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.blocks    (blocks),
		.pixels    (pixels)
	);

	pixel_t    pending_pixels[$];
	stim_row_t block_table[$];
	logic      fmt_shadow = FMT_DXT1;
	int        error_count = 0;
	int        cycle_count = 0;
	int        gap_odds = 0;
	int        stall_odds = 0;
	int        stall_left = 0;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic int widen5(input logic [4:0] c);
		int t;
		t = int'(c) * 255 + 16;
		return ((t / 32) + t) / 32;
	endfunction

	function automatic int widen6(input logic [5:0] c);
		int t;
		t = int'(c) * 255 + 32;
		return ((t / 64) + t) / 64;
	endfunction

	function automatic logic [7:0] dxt5_alpha(input int a0, input int a1, input logic [2:0] code);
		int c;
		c = int'(code);
		if (code == ACODE_A0)
			return 8'(a0);
		if (code == ACODE_A1)
			return 8'(a1);
		if (a0 > a1)
			return 8'(((8 - c) * a0 + (c - 1) * a1) / 7);
		if (code == ACODE_CLEAR)
			return dxt_pkg::AlphaClear;
		if (code == ACODE_OPAQUE)
			return dxt_pkg::AlphaOpaque;
		return 8'(((6 - c) * a0 + (c - 1) * a1) / 5);
	endfunction

	// Builds the palette of one block and queues its sixteen pixels.
	task automatic decode_block(input logic fmt, input logic [63:0] fw, input logic [63:0] sw);
		logic [63:0]    cw;
		logic           four;
		logic [1:0]     ci;
		int             a;
		int             b;
		dxt_pkg::rgb_t  pal [4];
		pixel_t         px;
		cw = (fmt == FMT_DXT5) ? sw : fw;
		four = (fmt == FMT_DXT5) || (cw[15:0] > cw[31:16]);
		pal[0].r = 8'(widen5(cw[15:11]));
		pal[0].g = 8'(widen6(cw[10:5]));
		pal[0].b = 8'(widen5(cw[4:0]));
		pal[1].r = 8'(widen5(cw[31:27]));
		pal[1].g = 8'(widen6(cw[26:21]));
		pal[1].b = 8'(widen5(cw[20:16]));
		for (int k = 0; k < 3; k++) begin
			a = int'(pal[0][8*k +: 8]);
			b = int'(pal[1][8*k +: 8]);
			pal[2][8*k +: 8] = four ? 8'((2 * a + b) / 3) : 8'((a + b) / 2);
			pal[3][8*k +: 8] = four ? 8'((a + 2 * b) / 3) : 8'd0;
		end
		for (int p = 0; p < 16; p++) begin
			ci = cw[32 + 2*p +: 2];
			px.idx = 4'(p);
			px.red = pal[ci].r;
			px.green = pal[ci].g;
			px.blue = pal[ci].b;
			if (fmt == FMT_DXT5)
				px.alpha = dxt5_alpha(int'(fw[7:0]), int'(fw[15:8]), fw[16 + 3*p +: 3]);
			else if (!four && ci == dxt_pkg::TransparentIndex)
				px.alpha = dxt_pkg::AlphaClear;
			else
				px.alpha = dxt_pkg::AlphaOpaque;
			px.last = (4'(p) == dxt_pkg::LastPixel);
			pending_pixels = {pending_pixels, px};
		end
	endtask

	task automatic add_row(input logic fmt, input logic [63:0] fw, input logic [63:0] sw,
			input logic typed, input logic [31:0] rgba);
		stim_row_t row;
		row.fmt = fmt;
		row.fw = fw;
		row.sw = sw;
		row.typed = typed;
		row.rgba = rgba;
		block_table = {block_table, row};
	endtask

	// Presents one block at the falling edge and holds it until the transaction.
	// Valid stays high afterwards; drain_pixels lowers it when no block follows.
	task automatic send_block(input logic [63:0] fw, input logic [63:0] sw,
			input logic typed, input logic [31:0] rgba);
		pixel_t px;
		if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			blocks.valid = 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		blocks.valid = 1'b1;
		blocks.first_word = fw;
		blocks.second_word = sw;
		@(posedge clk);
		while (!blocks.ready)
			@(posedge clk);
		if (typed) begin
			for (int p = 0; p < 16; p++) begin
				px.idx = 4'(p);
				{px.red, px.green, px.blue, px.alpha} = rgba;
				px.last = (4'(p) == dxt_pkg::LastPixel);
				pending_pixels = {pending_pixels, px};
			end
		end else begin
			decode_block(fmt_shadow, fw, sw);
		end
		@(negedge clk);
	endtask

	task automatic drain_pixels();
		blocks.valid = 1'b0;
		while (pending_pixels.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_format(input logic fmt);
		drain_pixels();
		cfg_we = 1'b1;
		cfg_wdata = fmt;
		@(negedge clk);
		cfg_we = 1'b0;
		fmt_shadow = fmt;
	endtask

	function automatic logic [63:0] random_colour_block();
		logic [63:0] cw;
		cw = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: cw[31:16] = cw[15:0];
			1: cw[15:0] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			2: cw[31:16] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			default: ;
		endcase
		return cw;
	endfunction

	function automatic logic [63:0] random_alpha_block();
		logic [63:0] aw;
		logic [2:0]  code;
		aw = {$urandom, $urandom};
		code = 3'($urandom_range(0, 7));
		case ($urandom_range(0, 7))
			0: aw[15:8] = aw[7:0];
			1: aw[7:0] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			2: aw[15:8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			3: begin
				for (int p = 0; p < 16; p++)
					aw[16 + 3*p +: 3] = code;
			end
			default: ;
		endcase
		return aw;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	// Receiver stalls come in bursts of random length.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			pixels.ready = 1'b0;
		end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
			stall_left = $urandom_range(0, 17);
			pixels.ready = 1'b0;
		end else begin
			pixels.ready = 1'b1;
		end
	end

	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && pixels.valid && pixels.ready) begin
			if (pending_pixels.size() == 0) begin
				$error("pixel transaction with no block pending: index %0d", pixels.pixel_index);
				error_count++;
			end else begin
				want = pending_pixels.pop_front();
				check_field("pixel_index", 8'(want.idx), 8'(pixels.pixel_index));
				check_field("red", want.red, pixels.red);
				check_field("green", want.green, pixels.green);
				check_field("blue", want.blue, pixels.blue);
				check_field("alpha", want.alpha, pixels.alpha);
				check_field("last_pixel", 8'(want.last), 8'(pixels.last_pixel));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int          odds_menu [3];
		stim_row_t   row;
		logic        phase_fmt;
		logic [63:0] fw;
		logic [63:0] sw;
		odds_menu = '{0, 3, 10};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		blocks.valid = 1'b0;
		blocks.first_word = '0;
		blocks.second_word = '0;
		pixels.ready = 1'b0;

		// DXT1 rows rely on the format register coming out of reset as DXT1.
		// The second word is junk on purpose there, since DXT1 ignores it.
		add_row(FMT_DXT1, 64'h0000_0000_0000_0000, 64'h0, 1'b1, 32'h0000_00FF);
		add_row(FMT_DXT1, 64'h0000_0000_0000_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
		add_row(FMT_DXT1, 64'h5555_5555_0000_FFFF, 64'h1234_5678_9ABC_DEF0, 1'b1, 32'h0000_00FF);
		add_row(FMT_DXT1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1, 32'h0000_0000);
		add_row(FMT_DXT1, 64'hAAAA_AAAA_0000_FFFF, 64'h0, 1'b1, 32'hAAAA_AAFF);
		add_row(FMT_DXT1, 64'hFFFF_FFFF_0000_FFFF, 64'h0, 1'b1, 32'h5555_55FF);
		add_row(FMT_DXT1, 64'hAAAA_AAAA_FFFF_0000, 64'h0, 1'b1, 32'h7F7F_7FFF);
		add_row(FMT_DXT1, 64'hE4E4_E4E4_F800_001F, 64'h0, 1'b0, 32'h0);
		add_row(FMT_DXT1, 64'h1B1B_1B1B_07E0_F81F, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0);
		add_row(FMT_DXT1, 64'h9C3A_5F21_7BEF_8410, 64'h0, 1'b0, 32'h0);
		add_row(FMT_DXT1, 64'hD827_63B1_39C6_39C6, 64'h0, 1'b0, 32'h0);
		add_row(FMT_DXT1, 64'h0123_4567_8000_7FFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0);
		// DXT5: every alpha code under both table modes, four-colour palette forced.
		add_row(FMT_DXT5, 64'h0000_0000_0000_00FF, 64'h0, 1'b1, 32'h0000_00FF);
		add_row(FMT_DXT5, 64'h2492_4924_9249_00FF, 64'h0, 1'b1, 32'h0000_0000);
		add_row(FMT_DXT5, 64'hFAC6_88FA_C688_20E0, 64'hE4E4_E4E4_FFFF_0000, 1'b0, 32'h0);
		add_row(FMT_DXT5, 64'hFAC6_88FA_C688_D030, 64'h1B1B_1B1B_F81F_07E0, 1'b0, 32'h0);
		add_row(FMT_DXT5, 64'hFAC6_88FA_C688_8080, 64'h9C3A_5F21_8410_7BEF, 1'b0, 32'h0);
		add_row(FMT_DXT5, 64'hDB6D_B6DB_6DB6_FF00, 64'hFFFF_FFFF_FFFF_0000, 1'b1, 32'hAAAA_AA00);
		add_row(FMT_DXT5, 64'hFFFF_FFFF_FFFF_FF00, 64'h0, 1'b1, 32'h0000_00FF);
		add_row(FMT_DXT5, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
		add_row(FMT_DXT5, 64'hFFFF_FFFF_FFFF_00FF, 64'h0, 1'b1, 32'h0000_0024);
		add_row(FMT_DXT5, 64'h5A3C_9E17_B2D4_6B94, 64'h3C5A_E187_4A29_D6B3, 1'b0, 32'h0);

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		gap_odds = 5;
		stall_odds = 5;
		foreach (block_table[i]) begin
			row = block_table[i];
			if (row.fmt != fmt_shadow)
				set_format(row.fmt);
			send_block(row.fw, row.sw, row.typed, row.rgba);
		end

		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			phase_fmt = (phase % 2 == 0) ? FMT_DXT1 : FMT_DXT5;
			set_format(phase_fmt);
			if (phase == PHASE_COUNT - 1) begin
				gap_odds = 0;
				stall_odds = 0;
				stall_left = 0;
			end else begin
				gap_odds = odds_menu[$urandom_range(0, 2)];
				stall_odds = odds_menu[$urandom_range(0, 2)];
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (phase_fmt == FMT_DXT5) begin
					fw = random_alpha_block();
					sw = random_colour_block();
				end else begin
					fw = random_colour_block();
					sw = {$urandom, $urandom};
				end
				send_block(fw, sw, 1'b0, 32'h0);
			end
		end

		drain_pixels();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### sim.f
rtl/dxt_pkg.sv
rtl/dxt_block_if.sv
rtl/dxt_pixel_if.sv
rtl/dxt_palette.sv
rtl/dxt_texture_block_decoder.sv
tb/sv/tb_top.sv
